### rtl/core/hds_pkg.sv
// Shared types for the heat diffusion stencil cell pipeline.
package hds_pkg;

	// Control that travels with every pipeline stage.
	typedef struct packed {
		logic valid;
		logic bypass;
	} hds_ctl_t;

	localparam int unsigned NumNbr = 4;

endpackage

### rtl/core/hds_mac.sv
// Saturation, weight products and accumulation: first two pipeline stages.
module hds_mac import hds_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16,
	parameter int unsigned TW = FRAC_BITS + 1,
	parameter int unsigned AW = 2 * FRAC_BITS + 3,
	parameter int unsigned DW = FRAC_BITS + 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [TW-1:0] outer_coeff,
	input  logic          in_valid,
	input  logic [TW-1:0] center_temp,
	input  logic [TW-1:0] nbr_temp [NumNbr],
	input  logic          nbr_insulator [NumNbr],
	input  logic          bypass,
	output hds_ctl_t      ctl,
	output logic [AW-1:0] acc,
	output logic [DW-1:0] contrib,
	output logic [TW-1:0] center
);

	localparam logic [TW-1:0] One = {1'b1, {FRAC_BITS{1'b0}}};
	localparam int unsigned PW = 2 * TW;

	logic [TW-1:0] outer_sat;
	logic [TW-1:0] inner;
	logic [TW-1:0] center_sat;
	logic [TW-1:0] nbr_sat [NumNbr];
	logic [DW-1:0] contrib_c;

	hds_ctl_t      ctl_s1;
	logic [PW-1:0] prod_center_s1;
	logic [PW-1:0] prod_nbr_s1 [NumNbr];
	logic [DW-1:0] contrib_s1;
	logic [TW-1:0] center_s1;

	hds_ctl_t      ctl_s2;
	logic [AW-1:0] acc_s2;
	logic [DW-1:0] contrib_s2;
	logic [TW-1:0] center_s2;

	always_comb begin
		outer_sat  = (outer_coeff > One) ? One : outer_coeff;
		inner      = One - (outer_sat >> 2);
		center_sat = (center_temp > One) ? One : center_temp;
		contrib_c  = DW'(inner);
		for (int k = 0; k < NumNbr; k++) begin
			nbr_sat[k] = (nbr_temp[k] > One) ? One : nbr_temp[k];
			if (!nbr_insulator[k]) begin
				contrib_c = contrib_c + DW'(outer_sat);
			end
		end
	end

	// Stage 1: one product per contributing cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid  <= in_valid;
			ctl_s1.bypass <= bypass;
		end
	end

	always_ff @(posedge clk) begin
		prod_center_s1 <= PW'(inner) * PW'(center_sat);
		for (int k = 0; k < NumNbr; k++) begin
			prod_nbr_s1[k] <= nbr_insulator[k] ? '0 : PW'(outer_sat) * PW'(nbr_sat[k]);
		end
		contrib_s1 <= contrib_c;
		center_s1  <= center_temp;
	end

	// Stage 2: weighted sum; its value never exceeds contrib times one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		acc_s2 <= (AW'(prod_center_s1) + AW'(prod_nbr_s1[0]))
			+ (AW'(prod_nbr_s1[1]) + AW'(prod_nbr_s1[2])) + AW'(prod_nbr_s1[3]);
		contrib_s2 <= contrib_s1;
		center_s2  <= center_s1;
	end

	assign ctl     = ctl_s2;
	assign acc     = acc_s2;
	assign contrib = contrib_s2;
	assign center  = center_s2;

endmodule

### rtl/core/hds_div_step.sv
// One restoring division stage: resolves a single quotient bit.
module hds_div_step import hds_pkg::*; #(
	parameter int unsigned SHIFT = 0,
	parameter int unsigned AW = 35,
	parameter int unsigned DW = 19,
	parameter int unsigned QW = 17,
	parameter int unsigned TW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hds_ctl_t      ctl_i,
	input  logic [AW-1:0] rem_i,
	input  logic [DW-1:0] div_i,
	input  logic [QW-1:0] quot_i,
	input  logic [TW-1:0] center_i,
	output hds_ctl_t      ctl_o,
	output logic [AW-1:0] rem_o,
	output logic [DW-1:0] div_o,
	output logic [QW-1:0] quot_o,
	output logic [TW-1:0] center_o
);

	logic [AW-1:0] div_shifted;
	logic [AW:0]   diff;
	logic          take;
	logic [QW-1:0] quot_next;

	always_comb begin
		div_shifted     = AW'(div_i) << SHIFT;
		diff            = {1'b0, rem_i} - {1'b0, div_shifted};
		take            = !diff[AW];
		quot_next       = quot_i;
		quot_next[SHIFT] = take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_o    <= take ? diff[AW-1:0] : rem_i;
		div_o    <= div_i;
		quot_o   <= quot_next;
		center_o <= center_i;
	end

endmodule

### rtl/core/heat_diffusion_stencil_cell_unit.sv
// Top level of the five-point heat diffusion stencil cell pipeline.
//
// channel   direction  handshake           payload
// config    in         cfg_we              cfg_data (outer_coeff)
// request   in         start & !busy       center/up/down/left/right temp, insulator flags
// result    out        done (one cycle)    new_temp
//
// One request per cycle; busy stays low. The pipeline has one product stage,
// one sum stage, one restoring division stage per quotient bit (FRAC_BITS + 1
// of them) and an output stage. Reset clears outer_coeff and all stage valid
// bits. The receiver cannot stall, so each result appears on done for exactly
// one cycle.
module heat_diffusion_stencil_cell_unit import hds_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [FRAC_BITS:0]   cfg_data,
	input  logic                 start,
	output logic                 busy,
	input  logic [FRAC_BITS:0]   center_temp,
	input  logic [FRAC_BITS:0]   up_temp,
	input  logic [FRAC_BITS:0]   down_temp,
	input  logic [FRAC_BITS:0]   left_temp,
	input  logic [FRAC_BITS:0]   right_temp,
	input  logic                 center_fixed,
	input  logic                 center_insulator,
	input  logic                 up_insulator,
	input  logic                 down_insulator,
	input  logic                 left_insulator,
	input  logic                 right_insulator,
	output logic                 done,
	output logic [FRAC_BITS:0]   new_temp
);

	localparam int unsigned TW = FRAC_BITS + 1;
	localparam int unsigned AW = 2 * FRAC_BITS + 3;
	localparam int unsigned DW = FRAC_BITS + 3;
	localparam int unsigned QW = FRAC_BITS + 1;
	localparam int unsigned Steps = FRAC_BITS + 1;
	localparam logic [TW-1:0] One = {1'b1, {FRAC_BITS{1'b0}}};

	logic [TW-1:0] outer_coeff_q;
	logic [TW-1:0] nbr_temp [NumNbr];
	logic          nbr_insulator [NumNbr];

	hds_ctl_t      ctl_w [Steps+1];
	logic [AW-1:0] rem_w [Steps+1];
	logic [DW-1:0] div_w [Steps+1];
	logic [QW-1:0] quot_w [Steps+1];
	logic [TW-1:0] center_w [Steps+1];

	logic          done_q;
	logic [TW-1:0] new_temp_q;
	logic [QW-1:0] quot_clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_coeff_q <= '0;
		end else if (cfg_we) begin
			outer_coeff_q <= cfg_data;
		end
	end

	assign busy = 1'b0;

	assign nbr_temp[0]      = up_temp;
	assign nbr_temp[1]      = down_temp;
	assign nbr_temp[2]      = left_temp;
	assign nbr_temp[3]      = right_temp;
	assign nbr_insulator[0] = up_insulator;
	assign nbr_insulator[1] = down_insulator;
	assign nbr_insulator[2] = left_insulator;
	assign nbr_insulator[3] = right_insulator;

	hds_mac #(
		.FRAC_BITS (FRAC_BITS),
		.TW        (TW),
		.AW        (AW),
		.DW        (DW)
	) u_mac (
		.clk           (clk),
		.arst_n        (arst_n),
		.outer_coeff   (outer_coeff_q),
		.in_valid      (start && !busy),
		.center_temp   (center_temp),
		.nbr_temp      (nbr_temp),
		.nbr_insulator (nbr_insulator),
		.bypass        (center_fixed || center_insulator),
		.ctl           (ctl_w[0]),
		.acc           (rem_w[0]),
		.contrib       (div_w[0]),
		.center        (center_w[0])
	);

	assign quot_w[0] = '0;

	// Quotient bits from the top down; the quotient never exceeds one
	for (genvar j = 0; j < Steps; j++) begin : g_div
		hds_div_step #(
			.SHIFT (FRAC_BITS - j),
			.AW    (AW),
			.DW    (DW),
			.QW    (QW),
			.TW    (TW)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_i    (ctl_w[j]),
			.rem_i    (rem_w[j]),
			.div_i    (div_w[j]),
			.quot_i   (quot_w[j]),
			.center_i (center_w[j]),
			.ctl_o    (ctl_w[j+1]),
			.rem_o    (rem_w[j+1]),
			.div_o    (div_w[j+1]),
			.quot_o   (quot_w[j+1]),
			.center_o (center_w[j+1])
		);
	end

	assign quot_clamped = (quot_w[Steps] > One) ? One : quot_w[Steps];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_w[Steps].valid;
		end
	end

	// Fixed or insulating center passes its raw value through
	always_ff @(posedge clk) begin
		new_temp_q <= ctl_w[Steps].bypass ? center_w[Steps] : quot_clamped;
	end

	assign done     = done_q;
	assign new_temp = new_temp_q;

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench for the heat diffusion stencil cell unit: queued cell requests, self-checking.
module tb import hds_pkg::*;;

	localparam int unsigned FRAC_BITS = 16;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [FRAC_BITS:0] TEMP_MAX = '1;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = FRAC_BITS + 8;
	localparam int RAND_PER_PHASE = 100;
	localparam int NUM_PHASES = 8;

	// Idle levels, percent of cycles the sender holds off
	localparam int IDLE_NONE = 0;
	localparam int IDLE_HEAVY = 47;
	localparam int IDLE_LIGHT = 20;

	// Flag sets: {center_fixed, center_insulator, up, down, left, right}
	localparam logic [5:0] F_NONE = 6'b000000;
	localparam logic [5:0] F_FIXED = 6'b100000;
	localparam logic [5:0] F_CINS = 6'b010000;
	localparam logic [5:0] F_UP = 6'b001000;
	localparam logic [5:0] F_DOWN = 6'b000100;
	localparam logic [5:0] F_LEFT = 6'b000010;
	localparam logic [5:0] F_RIGHT = 6'b000001;
	localparam logic [5:0] F_NBR_ALL = 6'b001111;

	typedef struct packed {
		logic [FRAC_BITS:0] center_temp;
		logic [FRAC_BITS:0] up_temp;
		logic [FRAC_BITS:0] down_temp;
		logic [FRAC_BITS:0] left_temp;
		logic [FRAC_BITS:0] right_temp;
		logic               center_fixed;
		logic               center_insulator;
		logic               up_insulator;
		logic               down_insulator;
		logic               left_insulator;
		logic               right_insulator;
	} cell_req_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [FRAC_BITS:0] cfg_data = '0;
	logic               start = 1'b0;
	logic               busy;
	logic               done;
	logic [FRAC_BITS:0] new_temp;
	cell_req_t          cur_req = '0;

	cell_req_t          cell_q[$];
	logic [FRAC_BITS:0] temp_q[$];
	logic [FRAC_BITS:0] outer_cfg = '0;
	int                 idle_pct = IDLE_NONE;
	int                 stall_cycles = 0;
	int                 n_req = 0;
	int                 n_res = 0;
	int                 n_bypass = 0;
	int                 n_err = 0;
	logic [FRAC_BITS:0] exp_temp;

	always #2 clk = ~clk;

	heat_diffusion_stencil_cell_unit #(
		.FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.center_temp(cur_req.center_temp),
		.up_temp(cur_req.up_temp),
		.down_temp(cur_req.down_temp),
		.left_temp(cur_req.left_temp),
		.right_temp(cur_req.right_temp),
		.center_fixed(cur_req.center_fixed),
		.center_insulator(cur_req.center_insulator),
		.up_insulator(cur_req.up_insulator),
		.down_insulator(cur_req.down_insulator),
		.left_insulator(cur_req.left_insulator),
		.right_insulator(cur_req.right_insulator),
		.done(done),
		.new_temp(new_temp)
	);

	function automatic logic [FRAC_BITS:0] sat_unit(logic [FRAC_BITS:0] v);
		return (v > ONE) ? ONE : v;
	endfunction

	// Weighted five-point average with saturation and clamp
	function automatic logic [FRAC_BITS:0] diffuse_cell(cell_req_t c, logic [FRAC_BITS:0] coeff);
		longint unsigned    w_out;
		longint unsigned    w_sum;
		longint unsigned    acc;
		longint unsigned    q;
		logic [FRAC_BITS:0] nbr_t [NumNbr];
		logic               nbr_ins [NumNbr];
		if (c.center_fixed || c.center_insulator)
			return c.center_temp;
		nbr_t = '{c.up_temp, c.down_temp, c.left_temp, c.right_temp};
		nbr_ins = '{c.up_insulator, c.down_insulator, c.left_insulator, c.right_insulator};
		w_out = 64'(sat_unit(coeff));
		w_sum = 64'(ONE) - (w_out >> 2);
		acc = w_sum * 64'(sat_unit(c.center_temp));
		for (int k = 0; k < NumNbr; k++) begin
			if (!nbr_ins[k]) begin
				w_sum += w_out;
				acc += w_out * 64'(sat_unit(nbr_t[k]));
			end
		end
		q = acc / w_sum;
		if (q > 64'(ONE))
			q = 64'(ONE);
		return q[FRAC_BITS:0];
	endfunction

	function automatic cell_req_t make_cell(logic [FRAC_BITS:0] c, logic [FRAC_BITS:0] u,
			logic [FRAC_BITS:0] d, logic [FRAC_BITS:0] l, logic [FRAC_BITS:0] r, logic [5:0] f);
		cell_req_t x;
		x.center_temp = c;
		x.up_temp = u;
		x.down_temp = d;
		x.left_temp = l;
		x.right_temp = r;
		{x.center_fixed, x.center_insulator, x.up_insulator, x.down_insulator,
			x.left_insulator, x.right_insulator} = f;
		return x;
	endfunction

	// Mostly in range, some extremes, some above one to hit saturation
	function automatic logic [FRAC_BITS:0] rand_temp();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70)
			return (FRAC_BITS + 1)'($urandom_range(ONE));
		else if (sel < 80)
			return ($urandom_range(1) != 0) ? ONE : '0;
		else
			return (FRAC_BITS + 1)'($urandom_range(TEMP_MAX));
	endfunction

	function automatic cell_req_t rand_cell();
		logic [5:0] f;
		f[5] = ($urandom_range(99) < 15);
		f[4] = ($urandom_range(99) < 15);
		for (int k = 0; k < 4; k++)
			f[k] = ($urandom_range(99) < 30);
		return make_cell(rand_temp(), rand_temp(), rand_temp(), rand_temp(), rand_temp(), f);
	endfunction

	// Driver: present queued requests, hold until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				temp_q.push_back(diffuse_cell(cur_req, outer_cfg));
				n_req++;
				if (cur_req.center_fixed || cur_req.center_insulator)
					n_bypass++;
			end
			if (!start || !busy) begin
				if (cell_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					cur_req <= cell_q.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result against the oldest expected temperature
	always @(posedge clk) begin
		if (arst_n && done) begin
			n_res++;
			if (temp_q.size() == 0) begin
				n_err++;
				$display("%0t: unexpected result new_temp=%0d, nothing expected", $time, new_temp);
			end else begin
				exp_temp = temp_q.pop_front();
				if (new_temp !== exp_temp) begin
					n_err++;
					$display("%0t: new_temp mismatch expected=%0d actual=%0d",
						$time, exp_temp, new_temp);
				end
			end
		end
	end

	// Watchdog: end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Timeout after %0d cycles without a request or result", stall_cycles);
				$display("Test completed with failures");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		logic [FRAC_BITS:0] coeff_tbl [NUM_PHASES];
		int                 idle_tbl [NUM_PHASES];
		coeff_tbl = '{'0, ONE, TEMP_MAX, (FRAC_BITS + 1)'(1), ONE >> 2, ONE - 1'b1,
			(FRAC_BITS + 1)'($urandom_range(TEMP_MAX)), (FRAC_BITS + 1)'($urandom_range(ONE))};
		idle_tbl = '{IDLE_NONE, IDLE_HEAVY, IDLE_LIGHT, IDLE_NONE,
			IDLE_HEAVY, IDLE_LIGHT, IDLE_NONE, IDLE_HEAVY};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			// Phase 0 runs on the reset value of the coefficient
			if (p != 0) begin
				@(posedge clk);
				cfg_we <= 1'b1;
				cfg_data <= coeff_tbl[p];
				@(posedge clk);
				cfg_we <= 1'b0;
				outer_cfg = coeff_tbl[p];
			end
			@(negedge clk);
			idle_pct = idle_tbl[p];
			if (p == 1) begin
				cell_q.push_back(make_cell('0, '0, '0, '0, '0, F_NONE));
				cell_q.push_back(make_cell(ONE, ONE, ONE, ONE, ONE, F_NONE));
				cell_q.push_back(make_cell(TEMP_MAX, TEMP_MAX, TEMP_MAX, TEMP_MAX, TEMP_MAX,
					F_NONE));
				cell_q.push_back(make_cell('0, ONE, ONE, ONE, ONE, F_NONE));
				cell_q.push_back(make_cell(ONE, '0, '0, '0, '0, F_NONE));
				// Pass-through keeps values above one
				cell_q.push_back(make_cell(TEMP_MAX, '0, ONE, '0, ONE, F_FIXED));
				cell_q.push_back(make_cell(TEMP_MAX, '0, '0, '0, '0, F_CINS));
				cell_q.push_back(make_cell(17'd12345, ONE, ONE, ONE, ONE, F_FIXED | F_CINS));
				cell_q.push_back(make_cell('0, ONE, ONE, ONE, ONE, F_FIXED | F_NBR_ALL));
				// Only the center contributes
				cell_q.push_back(make_cell(17'd100000, '0, '0, '0, '0, F_NBR_ALL));
				cell_q.push_back(make_cell(17'd30000, ONE, ONE, ONE, ONE, F_NBR_ALL));
				// One live neighbor at a time
				cell_q.push_back(make_cell('0, ONE, TEMP_MAX, TEMP_MAX, TEMP_MAX,
					F_DOWN | F_LEFT | F_RIGHT));
				cell_q.push_back(make_cell('0, TEMP_MAX, ONE, TEMP_MAX, TEMP_MAX,
					F_UP | F_LEFT | F_RIGHT));
				cell_q.push_back(make_cell('0, TEMP_MAX, TEMP_MAX, ONE, TEMP_MAX,
					F_UP | F_DOWN | F_RIGHT));
				cell_q.push_back(make_cell('0, TEMP_MAX, TEMP_MAX, TEMP_MAX, ONE,
					F_UP | F_DOWN | F_LEFT));
				cell_q.push_back(make_cell(17'h0AAAA, 17'h15555, 17'h0AAAA, 17'h15555,
					17'h0AAAA, F_NONE));
				cell_q.push_back(make_cell(17'd1, ONE - 1'b1, ONE - 1'b1, ONE - 1'b1,
					ONE - 1'b1, F_NONE));
				cell_q.push_back(make_cell(ONE - 1'b1, 17'd1, 17'd1, 17'd1, 17'd1, F_UP));
				cell_q.push_back(make_cell('0, TEMP_MAX, TEMP_MAX, TEMP_MAX, TEMP_MAX, F_FIXED));
			end
			for (int i = 0; i < RAND_PER_PHASE; i++)
				cell_q.push_back(rand_cell());
			// Drain completely before the next coefficient write
			while (cell_q.size() != 0 || start || temp_q.size() != 0)
				@(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d cell requests over %0d coefficient settings, %0d with a fixed or",
			n_req, NUM_PHASES, n_bypass);
		$display("insulating center; %0d results checked, %0d mismatches", n_res, n_err);
		if (n_err == 0 && temp_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
